// ===== hdl/r3tb_pkg.sv =====
`timescale 1ns / 1ps

package r3tb_pkg;

    // default sample width and twiddle fraction bits
    localparam int DEF_SAMPLE_WIDTH      = 24;
    localparam int DEF_TWIDDLE_FRAC_BITS = 16;

    // sqrt(3)/2 in Q0.32, rounded to nearest to the twiddle format in the datapath
    localparam longint unsigned C_Q32 = 64'd3719550787;

    // number of register stages from the input transfer to the result register
    localparam int PIPE_DEPTH = 7;

endpackage

// ===== hdl/r3tb_in_if.sv =====
`timescale 1ns / 1ps

interface r3tb_in_if #(
    parameter int SAMPLE_WIDTH      = r3tb_pkg::DEF_SAMPLE_WIDTH,
    parameter int TWIDDLE_FRAC_BITS = r3tb_pkg::DEF_TWIDDLE_FRAC_BITS
);
    localparam int TW = TWIDDLE_FRAC_BITS + 2;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] x0_re;
    logic signed [SAMPLE_WIDTH-1:0] x0_im;
    logic signed [SAMPLE_WIDTH-1:0] x1_re;
    logic signed [SAMPLE_WIDTH-1:0] x1_im;
    logic signed [SAMPLE_WIDTH-1:0] x2_re;
    logic signed [SAMPLE_WIDTH-1:0] x2_im;
    logic signed [TW-1:0]           tw1_re;
    logic signed [TW-1:0]           tw1_im;
    logic signed [TW-1:0]           tw2_re;
    logic signed [TW-1:0]           tw2_im;

    modport source (
        output valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im,
        output tw1_re, tw1_im, tw2_re, tw2_im,
        input  ready
    );

    modport sink (
        input  valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im,
        input  tw1_re, tw1_im, tw2_re, tw2_im,
        output ready
    );

endinterface

// ===== hdl/r3tb_out_if.sv =====
`timescale 1ns / 1ps

interface r3tb_out_if #(
    parameter int SAMPLE_WIDTH = r3tb_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] y0_re;
    logic signed [SAMPLE_WIDTH-1:0] y0_im;
    logic signed [SAMPLE_WIDTH-1:0] y1_re;
    logic signed [SAMPLE_WIDTH-1:0] y1_im;
    logic signed [SAMPLE_WIDTH-1:0] y2_re;
    logic signed [SAMPLE_WIDTH-1:0] y2_im;

    modport source (
        output valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im,
        input  ready
    );

    modport sink (
        input  valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im,
        output ready
    );

endinterface

// ===== hdl/radix3_twiddle_butterfly.sv =====
// Radix-3 FFT butterfly with twiddles. Each transfer on samples brings x0, x1, x2 and the
// twiddles w1, w2 (Q1.TWIDDLE_FRAC_BITS); the block forms a = w1*x1, b = w2*x2 and returns
// X0 = x0 + a + b, X1 = m + j*c*(a-b), X2 = m - j*c*(a-b) with m = x0 - (a+b)/2 and
// c = sqrt(3)/2 quantized to TWIDDLE_FRAC_BITS fraction bits. Each result is rounded once
// to nearest (ties toward plus infinity) and saturated to SAMPLE_WIDTH bits. Throughput is
// one butterfly per clock while results takes each result; the result reaches results
// through the seven register stages (twiddle multiply, complex add, sum and difference,
// c multiply in two halves, recombine, final add, round and saturate).
// Back-pressure on results stalls only the stages that are full, so empty stages keep
// taking new transfers; ready on samples is formed combinationally from ready on results.
`timescale 1ns / 1ps

module radix3_twiddle_butterfly #(
    parameter int SAMPLE_WIDTH      = r3tb_pkg::DEF_SAMPLE_WIDTH,
    parameter int TWIDDLE_FRAC_BITS = r3tb_pkg::DEF_TWIDDLE_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    r3tb_in_if.sink     samples,
    r3tb_out_if.source  results
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int F   = TWIDDLE_FRAC_BITS;
    localparam int TW  = F + 2;
    localparam int PW  = SW + TW;          // one twiddle product
    localparam int AW  = PW + 1;           // a, b
    localparam int DW  = AW + 1;           // s, d
    localparam int Y0W = DW + 2;           // x0 + s with rounding offset
    localparam int M2W = DW + 1;           // m in units of 2^-(F+1)
    localparam int DL  = DW / 2;           // low half of d for the c multiply
    localparam int DH  = DW - DL;          // high half of d
    localparam int LPW = F + DL + 2;       // c times low half
    localparam int HPW = F + 1 + DH;       // c times high half
    localparam int CDW = DW + F + 1;       // c times d
    localparam int VW  = DW + F + 3;       // m*2^(F-1) +- c*d + rounding
    localparam int ND  = r3tb_pkg::PIPE_DEPTH;

    // c = sqrt(3)/2, rounded to F fraction bits
    localparam logic [F-1:0] C_COEF =
        F'((r3tb_pkg::C_Q32 + (64'd1 << (31 - F))) >> (32 - F));

    localparam logic signed [Y0W-1:0] RND_Y0 = Y0W'(1) << (F - 1);
    localparam logic signed [VW-1:0]  RND_V  = VW'(1) << (2 * F - 1);
    localparam logic signed [SW-1:0]  SAT_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0]  SAT_MIN = {1'b1, {(SW - 1){1'b0}}};

    // take bits [F+SW-1:F] of the rounded sum, clamp when the upper bits are not a sign run
    function automatic logic signed [SW-1:0] sat_y0(input logic signed [Y0W-1:0] v);
        if ((&v[Y0W-1:F+SW-1]) || !(|v[Y0W-1:F+SW-1]))
            return v[F+SW-1:F];
        else
            return v[Y0W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // same for the twice-scaled outputs, result in bits [2F+SW-1:2F]
    function automatic logic signed [SW-1:0] sat_v(input logic signed [VW-1:0] v);
        if ((&v[VW-1:2*F+SW-1]) || !(|v[VW-1:2*F+SW-1]))
            return v[2*F+SW-1:2*F];
        else
            return v[VW-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // ---------------------------------------------------------------------------------
    // stage control: a stage loads when it is empty or the stage after it moves on
    // ---------------------------------------------------------------------------------
    logic [ND-1:0] vld_reg;
    logic [ND-1:0] vld_next;
    logic [ND-1:0] en;

    always_comb
    begin
        en[ND-1] = !vld_reg[ND-1] || results.ready;
        for (int k = ND - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? samples.valid : vld_reg[0];
        for (int k = 1; k < ND; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign samples.ready = en[0];
    assign results.valid = vld_reg[ND-1];

    // ---------------------------------------------------------------------------------
    // stage 1: the eight real products of the two twiddle multiplies
    // ---------------------------------------------------------------------------------
    logic signed [PW-1:0] p1_rr_reg, p1_ii_reg, p1_ri_reg, p1_ir_reg;
    logic signed [PW-1:0] p2_rr_reg, p2_ii_reg, p2_ri_reg, p2_ir_reg;
    logic signed [SW-1:0] x0_re1_reg, x0_im1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1_rr_reg  <= PW'(samples.tw1_re) * PW'(samples.x1_re);
            p1_ii_reg  <= PW'(samples.tw1_im) * PW'(samples.x1_im);
            p1_ri_reg  <= PW'(samples.tw1_re) * PW'(samples.x1_im);
            p1_ir_reg  <= PW'(samples.tw1_im) * PW'(samples.x1_re);
            p2_rr_reg  <= PW'(samples.tw2_re) * PW'(samples.x2_re);
            p2_ii_reg  <= PW'(samples.tw2_im) * PW'(samples.x2_im);
            p2_ri_reg  <= PW'(samples.tw2_re) * PW'(samples.x2_im);
            p2_ir_reg  <= PW'(samples.tw2_im) * PW'(samples.x2_re);
            x0_re1_reg <= samples.x0_re;
            x0_im1_reg <= samples.x0_im;
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 2: a = w1*x1, b = w2*x2
    // ---------------------------------------------------------------------------------
    logic signed [AW-1:0] a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic signed [SW-1:0] x0_re2_reg, x0_im2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a_re_reg   <= AW'(p1_rr_reg) - AW'(p1_ii_reg);
            a_im_reg   <= AW'(p1_ri_reg) + AW'(p1_ir_reg);
            b_re_reg   <= AW'(p2_rr_reg) - AW'(p2_ii_reg);
            b_im_reg   <= AW'(p2_ri_reg) + AW'(p2_ir_reg);
            x0_re2_reg <= x0_re1_reg;
            x0_im2_reg <= x0_im1_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 3: s = a + b, d = a - b
    // ---------------------------------------------------------------------------------
    logic signed [DW-1:0] s_re_reg, s_im_reg, d_re_reg, d_im_reg;
    logic signed [SW-1:0] x0_re3_reg, x0_im3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s_re_reg   <= DW'(a_re_reg) + DW'(b_re_reg);
            s_im_reg   <= DW'(a_im_reg) + DW'(b_im_reg);
            d_re_reg   <= DW'(a_re_reg) - DW'(b_re_reg);
            d_im_reg   <= DW'(a_im_reg) - DW'(b_im_reg);
            x0_re3_reg <= x0_re2_reg;
            x0_im3_reg <= x0_im2_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 4: X0 before rounding, m at twice the scale, c*d split in two halves
    // ---------------------------------------------------------------------------------
    logic signed [Y0W-1:0] y0s_re_reg, y0s_im_reg;
    logic signed [M2W-1:0] m2_re4_reg, m2_im4_reg;
    logic signed [LPW-1:0] clo_re_reg, clo_im_reg;
    logic signed [HPW-1:0] chi_re_reg, chi_im_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            y0s_re_reg <= (Y0W'(x0_re3_reg) <<< F) + Y0W'(s_re_reg) + RND_Y0;
            y0s_im_reg <= (Y0W'(x0_im3_reg) <<< F) + Y0W'(s_im_reg) + RND_Y0;
            m2_re4_reg <= (M2W'(x0_re3_reg) <<< (F + 1)) - M2W'(s_re_reg);
            m2_im4_reg <= (M2W'(x0_im3_reg) <<< (F + 1)) - M2W'(s_im_reg);
            clo_re_reg <= LPW'($signed({1'b0, C_COEF}))
                          * LPW'($signed({1'b0, d_re_reg[DL-1:0]}));
            clo_im_reg <= LPW'($signed({1'b0, C_COEF}))
                          * LPW'($signed({1'b0, d_im_reg[DL-1:0]}));
            chi_re_reg <= HPW'($signed({1'b0, C_COEF})) * HPW'($signed(d_re_reg[DW-1:DL]));
            chi_im_reg <= HPW'($signed({1'b0, C_COEF})) * HPW'($signed(d_im_reg[DW-1:DL]));
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 5: recombine c*d, round and clamp X0
    // ---------------------------------------------------------------------------------
    logic signed [CDW-1:0] cd_re_reg, cd_im_reg;
    logic signed [M2W-1:0] m2_re5_reg, m2_im5_reg;
    logic signed [SW-1:0]  y0_re5_reg, y0_im5_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            cd_re_reg  <= (CDW'(chi_re_reg) <<< DL) + CDW'(clo_re_reg);
            cd_im_reg  <= (CDW'(chi_im_reg) <<< DL) + CDW'(clo_im_reg);
            m2_re5_reg <= m2_re4_reg;
            m2_im5_reg <= m2_im4_reg;
            y0_re5_reg <= sat_y0(y0s_re_reg);
            y0_im5_reg <= sat_y0(y0s_im_reg);
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 6: m +- j*c*d at scale 2^(2F), with the rounding offset folded in
    // ---------------------------------------------------------------------------------
    logic signed [VW-1:0] v1_re_reg, v1_im_reg, v2_re_reg, v2_im_reg;
    logic signed [SW-1:0] y0_re6_reg, y0_im6_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            v1_re_reg  <= (VW'(m2_re5_reg) <<< (F - 1)) - VW'(cd_im_reg) + RND_V;
            v1_im_reg  <= (VW'(m2_im5_reg) <<< (F - 1)) + VW'(cd_re_reg) + RND_V;
            v2_re_reg  <= (VW'(m2_re5_reg) <<< (F - 1)) + VW'(cd_im_reg) + RND_V;
            v2_im_reg  <= (VW'(m2_im5_reg) <<< (F - 1)) - VW'(cd_re_reg) + RND_V;
            y0_re6_reg <= y0_re5_reg;
            y0_im6_reg <= y0_im5_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 7: result register, held while results is stalled
    // ---------------------------------------------------------------------------------
    logic signed [SW-1:0] y0_re_reg, y0_im_reg, y1_re_reg, y1_im_reg, y2_re_reg, y2_im_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            y0_re_reg <= y0_re6_reg;
            y0_im_reg <= y0_im6_reg;
            y1_re_reg <= sat_v(v1_re_reg);
            y1_im_reg <= sat_v(v1_im_reg);
            y2_re_reg <= sat_v(v2_re_reg);
            y2_im_reg <= sat_v(v2_im_reg);
        end
    end

    assign results.y0_re = y0_re_reg;
    assign results.y0_im = y0_im_reg;
    assign results.y1_re = y1_re_reg;
    assign results.y1_im = y1_im_reg;
    assign results.y2_re = y2_re_reg;
    assign results.y2_im = y2_im_reg;

endmodule

// ===== hdl/r3tb_checker.sv =====
`timescale 1ns / 1ps

module r3tb_checker #(
    parameter int SAMPLE_WIDTH = r3tb_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] y0_re,
    input logic [SAMPLE_WIDTH-1:0] y0_im,
    input logic [SAMPLE_WIDTH-1:0] y1_re,
    input logic [SAMPLE_WIDTH-1:0] y1_im,
    input logic [SAMPLE_WIDTH-1:0] y2_re,
    input logic [SAMPLE_WIDTH-1:0] y2_im
);

    localparam int ND = r3tb_pkg::PIPE_DEPTH;
    localparam int CW = $clog2(ND + 1);

    logic          in_xfer;
    logic          out_xfer;
    logic [CW-1:0] inflight_reg;
    logic [CW-1:0] inflight_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg + {{(CW - 1){1'b0}}, in_xfer}
                        - {{(CW - 1){1'b0}}, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a stalled result stays up unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(y0_re) && $stable(y0_im)
            && $stable(y1_re) && $stable(y1_im) && $stable(y2_re) && $stable(y2_im))
        else $error("stalled result changed or dropped");

    // the pipeline never holds back input on its own
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while results is ready");

    // no more items in flight than there are stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CW'(ND))
        else $error("more items in flight than pipeline stages");

    // every result belongs to an accepted item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result shown with no item in flight");

endmodule

bind radix3_twiddle_butterfly r3tb_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_r3tb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .y0_re     (results.y0_re),
    .y0_im     (results.y0_im),
    .y1_re     (results.y1_re),
    .y1_im     (results.y1_im),
    .y2_re     (results.y2_re),
    .y2_im     (results.y2_im)
);
